// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files of the edge acceptor.
// Depends on a clock named clock and an active-high reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clock, skipped while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that an expression is never true at a rising edge of clock.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== sv/ufea_pkg.sv =====
// Package for the union-find edge acceptor: sizes, vertex type, store request.
// No dependencies; used by every module of the block.
package ufea_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int VTX_BITS     = $clog2(MAX_VERTICES);
   localparam int VC_BITS      = 9;
   localparam int WEIGHT_BITS  = 16;
   localparam int SUM_BITS     = 32;

   localparam logic [VC_BITS-1:0] VC_MAX   = VC_BITS'(MAX_VERTICES);
   localparam logic [VC_BITS-1:0] VC_RESET = VC_BITS'(256);

   typedef logic [VTX_BITS-1:0] vtx_type;

   // Request from the sequencer to the parent store for one cycle.
   typedef struct packed {
      logic    clear;
      logic    rd_en;
      vtx_type rd_addr;
      logic    wr_en;
      vtx_type wr_addr;
      vtx_type wr_data;
   } ufea_mem_req_type;

endpackage

// ===== sv/ufea_parent_store.sv =====
// Parent-link memory with per-entry valid bits; an invalid entry reads as its own index.
// Depends on ufea_pkg.
module ufea_parent_store
   import ufea_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ufea_mem_req_type mem_req,
   output vtx_type          parent
);

   vtx_type                  mem_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]  valid_ff;
   vtx_type                  rd_data_ff;
   vtx_type                  rd_addr_ff;
   logic                     rd_valid_ff;

   // Memory array: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
         rd_addr_ff <= mem_req.rd_addr;
      end
   end

   // Valid bits: drop all on reset or clear, set on write.
   always_ff @(posedge clock) begin
      if (reset || mem_req.clear) begin
         valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         valid_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (mem_req.rd_en) begin
         rd_valid_ff <= valid_ff[mem_req.rd_addr] & ~mem_req.clear;
      end
   end

   assign parent = rd_valid_ff ? rd_data_ff : rd_addr_ff;

   `include "assert_macros.svh"

   `ASSERT_NEVER(a_no_rw_same_cycle, mem_req.wr_en && mem_req.rd_en, "store read and write collide")
   `ASSERT_NEVER(a_no_clear_with_write, mem_req.clear && mem_req.wr_en, "store clear during write")
   `ASSERT_CLK(a_clear_reads_identity, mem_req.clear && mem_req.rd_en |=> parent == rd_addr_ff,
      "read after clear is not identity")

endmodule

// ===== sv/ufea_ctrl.sv =====
// Sequencer: range check, root walks through the shared compare, link and saturating sum.
// Depends on ufea_pkg; drives ufea_parent_store through a ufea_mem_req_type request.
module ufea_ctrl
   import ufea_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [7:0]             src_vertex,
   input  logic [7:0]             dst_vertex,
   input  logic [WEIGHT_BITS-1:0] weight,
   input  logic                   new_graph,
   input  logic [VC_BITS-1:0]     vertex_count,
   input  vtx_type                parent,
   output ufea_mem_req_type       mem_req,
   output logic                   rsp_strobe,
   output logic                   rsp_accepted,
   output logic                   rsp_bad_vertex,
   output logic [SUM_BITS-1:0]    rsp_running_total
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SRC  = 2'd1;
   localparam logic [1:0] ST_DST  = 2'd2;

   logic [1:0]             state_ff, state_in;
   vtx_type                cur_ff, cur_in;
   vtx_type                rs_ff, rs_in;
   vtx_type                dst_ff, dst_in;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic                   strobe_ff, strobe_in;
   logic                   acc_ff, acc_in;
   logic                   bad_ff, bad_in;

   logic                   accept;
   logic [VC_BITS-1:0]     limit;
   logic                   is_bad;
   logic                   at_root;
   logic [SUM_BITS:0]      sum_wide;
   logic [SUM_BITS-1:0]    sum_sat;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign limit   = (vertex_count > VC_MAX) ? VC_MAX : vertex_count;
   assign is_bad  = ({1'b0, src_vertex} >= limit) || ({1'b0, dst_vertex} >= limit);
   assign at_root = (parent == cur_ff);

   assign sum_wide = {1'b0, sum_ff} + (SUM_BITS+1)'(weight_ff);
   assign sum_sat  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      rs_in     = rs_ff;
      dst_in    = dst_ff;
      weight_in = weight_ff;
      sum_in    = sum_ff;
      strobe_in = 1'b0;
      acc_in    = acc_ff;
      bad_in    = bad_ff;
      mem_req   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dst_in    = vtx_type'(dst_vertex);
               weight_in = weight;
               if (new_graph) begin
                  sum_in        = '0;
                  mem_req.clear = 1'b1;
               end
               if (is_bad) begin
                  strobe_in = 1'b1;
                  acc_in    = 1'b0;
                  bad_in    = 1'b1;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = vtx_type'(src_vertex);
                  cur_in          = vtx_type'(src_vertex);
                  state_in        = ST_SRC;
               end
            end
         end
         ST_SRC: begin
            mem_req.rd_en = 1'b1;
            if (at_root) begin
               rs_in           = cur_ff;
               cur_in          = dst_ff;
               mem_req.rd_addr = dst_ff;
               state_in        = ST_DST;
            end else begin
               cur_in          = parent;
               mem_req.rd_addr = parent;
            end
         end
         ST_DST: begin
            if (at_root) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
               bad_in    = 1'b0;
               if (rs_ff != cur_ff) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = rs_ff;
                  mem_req.wr_data = cur_ff;
                  sum_in          = sum_sat;
                  acc_in          = 1'b1;
               end else begin
                  acc_in = 1'b0;
               end
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = parent;
               cur_in          = parent;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sum_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sum_ff    <= sum_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      rs_ff     <= rs_in;
      dst_ff    <= dst_in;
      weight_ff <= weight_in;
      acc_ff    <= acc_in;
      bad_ff    <= bad_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_accepted      = acc_ff;
   assign rsp_bad_vertex    = bad_ff;
   assign rsp_running_total = sum_ff;

   `include "assert_macros.svh"

   `ASSERT_CLK(a_accept_makes_progress, accept |=> busy || rsp_strobe,
      "accepted edge neither walks nor reports")
   `ASSERT_CLK(a_link_not_self, mem_req.wr_en |-> mem_req.wr_addr != mem_req.wr_data,
      "root linked to itself")
   `ASSERT_CLK(a_write_only_at_link, mem_req.wr_en |-> state_ff == ST_DST && at_root,
      "store write outside link step")
   `ASSERT_NEVER(a_flags_exclusive, rsp_strobe && rsp_accepted && rsp_bad_vertex,
      "edge both accepted and bad")

endmodule

// ===== sv/union_find_edge_acceptor.sv =====
// Union-find edge acceptor: start/busy command port, APB-style register port.
// A bad edge strobes in the cycle after accept; a good edge walks the source, then the
// destination, to its root (one store read a step), then links distinct roots and strobes.
// Throughput: busy stays high until the strobe cycle; the next edge may start in it.
// Reset (reset, synchronous, active high): all parent links to identity, total to zero,
// vertex_count to 256; results are single-cycle strobes that the receiver cannot hold off.
module union_find_edge_acceptor
   import ufea_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Edge command channel
   input  logic                   start,
   output logic                   busy,
   input  logic [7:0]             req_source_vertex,
   input  logic [7:0]             req_dest_vertex,
   input  logic [WEIGHT_BITS-1:0] req_edge_weight,
   input  logic                   req_new_graph,
   // Result channel
   output logic                   rsp_strobe,
   output logic                   rsp_accepted,
   output logic                   rsp_bad_vertex,
   output logic [SUM_BITS-1:0]    rsp_running_total,
   // Register port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [VC_BITS-1:0] vertex_count_ff, vertex_count_in;
   logic               csr_hit;
   logic               csr_wr;
   ufea_mem_req_type   mem_req;
   vtx_type            parent;

   // Register map: vertex_count at byte address 0; address 4 is unmapped.
   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == 1'b0);
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;

   // Capture the written beat's low bits; hold otherwise.
   assign vertex_count_in = csr_wr ? pwdata[VC_BITS-1:0] : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VC_RESET;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   // Read back the register at its address, zero elsewhere.
   assign prdata = csr_hit ? {{(32-VC_BITS){1'b0}}, vertex_count_ff} : '0;

   // Sequencer: range check, root walk of each endpoint through one compare, then link
   // the source root under the destination root and advance the saturating total.
   ufea_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .src_vertex        (req_source_vertex),
      .dst_vertex        (req_dest_vertex),
      .weight            (req_edge_weight),
      .new_graph         (req_new_graph),
      .vertex_count      (vertex_count_ff),
      .parent            (parent),
      .mem_req           (mem_req),
      .rsp_strobe        (rsp_strobe),
      .rsp_accepted      (rsp_accepted),
      .rsp_bad_vertex    (rsp_bad_vertex),
      .rsp_running_total (rsp_running_total)
   );

   // Parent links; valid bits make a fresh graph read as identity without a sweep.
   ufea_parent_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .parent  (parent)
   );

endmodule
